>>> hw/rtl/ddsbp_pkg.sv
// Shared types and constants for the two-channel DDS burst player.
`timescale 1ns / 1ps
`default_nettype none

package ddsbp_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_W    = 12;
  localparam int STEP_W      = ADDR_W + FRAC_BITS;
  localparam int PHASE_W     = STEP_W + 1;
  localparam int LIMIT_W     = 17;
  localparam int COUNT_W     = 16;
  localparam int DAC_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = STEP_W;

  localparam logic [DAC_W-1:0] PREFIX_A = 16'h3000;
  localparam logic [DAC_W-1:0] PREFIX_B = 16'hB000;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_ARM   = 2'd1,
    ACT_START = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_A  = 2'd0,
    REG_STEP_B  = 2'd1,
    REG_LIMIT_A = 2'd2,
    REG_LIMIT_B = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_kind_t;

  // addr_a doubles as the write address of a table write
  typedef struct packed {
    cmd_kind_t           kind;
    logic                chan;
    logic                en_a;
    logic                en_b;
    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [DAC_W-1:0] dac_word;
    logic             from_channel;
    logic             last;
  } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/ddsbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ddsbp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ddsbp_fifo.sv
// Generic synchronous FIFO built from flip-flops.
`timescale 1ns / 1ps
`default_nettype none

module ddsbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push_ok) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop_ok) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fifo occupancy beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("fifo occupancy did not grow on lone push");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> (wptr_r == rptr_r))
    else $error("fifo pointers disagree with occupancy");

endmodule

`default_nettype wire

>>> hw/rtl/ddsbp_front.sv
// Front end: takes input transactions, keeps phase and period state, queues commands.
`timescale 1ns / 1ps
`default_nettype none

module ddsbp_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 push,
  input  wire logic [1:0]                           action,
  input  wire logic                                 channel,
  input  wire logic [ddsbp_pkg::ADDR_W-1:0]         table_index,
  input  wire logic [ddsbp_pkg::SAMPLE_W-1:0]       table_sample,
  input  wire logic                                 cfg_we,
  input  wire logic [ddsbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ddsbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                 cmd_full,
  output logic                                      cmd_push,
  output ddsbp_pkg::cmd_t                           cmd
);

  import ddsbp_pkg::*;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COUNT_W-1:0] done;
    logic               en;
    logic [ADDR_W-1:0]  idx;
  } chan_res_t;

  // Wrap, count a period, check the limit, then advance if still enabled
  function automatic chan_res_t chan_tick(
    input logic [PHASE_W-1:0] phase,
    input logic [COUNT_W-1:0] done,
    input logic               en,
    input logic [LIMIT_W-1:0] limit,
    input logic [STEP_W-1:0]  step
  );
    logic               wrap;
    logic [PHASE_W-1:0] ph;
    chan_res_t          res;
    wrap      = phase[PHASE_W-1];
    ph        = {1'b0, phase[PHASE_W-2:0]};
    res.done  = done + COUNT_W'(wrap);
    res.en    = en && !(!limit[LIMIT_W-1] && (res.done == limit[COUNT_W-1:0]));
    res.idx   = ph[FRAC_BITS +: ADDR_W];
    res.phase = ph + (res.en ? {1'b0, step} : '0);
    return res;
  endfunction

  logic [STEP_W-1:0]  step_a_r, step_b_r;
  logic [LIMIT_W-1:0] limit_a_r, limit_b_r;
  logic [PHASE_W-1:0] phase_a_r, phase_a_nxt, phase_b_r, phase_b_nxt;
  logic [COUNT_W-1:0] done_a_r, done_a_nxt, done_b_r, done_b_nxt;
  logic               en_a_r, en_a_nxt, en_b_r, en_b_nxt;
  logic               accept;
  chan_res_t          res_a, res_b;
  action_t            act;

  assign accept = push && !cmd_full;
  assign act    = action_t'(action);
  assign res_a  = chan_tick(phase_a_r, done_a_r, en_a_r, limit_a_r, step_a_r);
  assign res_b  = chan_tick(phase_b_r, done_b_r, en_b_r, limit_b_r, step_b_r);

  always_comb begin
    phase_a_nxt = phase_a_r;
    phase_b_nxt = phase_b_r;
    done_a_nxt  = done_a_r;
    done_b_nxt  = done_b_r;
    en_a_nxt    = en_a_r;
    en_b_nxt    = en_b_r;
    cmd_push    = 1'b0;
    cmd.kind    = CMD_WRITE;
    cmd.chan    = channel;
    cmd.en_a    = res_a.en;
    cmd.en_b    = res_b.en;
    cmd.addr_a  = table_index;
    cmd.addr_b  = res_b.idx;
    cmd.sample  = table_sample;
    if (accept) begin
      case (act)
        ACT_WRITE: begin
          cmd_push = 1'b1;
        end
        ACT_ARM: begin
          if (channel) begin
            en_b_nxt = 1'b1;
          end else begin
            en_a_nxt = 1'b1;
          end
        end
        ACT_START: begin
          phase_a_nxt = '0;
          phase_b_nxt = '0;
          done_a_nxt  = '0;
          done_b_nxt  = '0;
          en_a_nxt    = 1'b1;
          en_b_nxt    = 1'b1;
        end
        ACT_TICK: begin
          phase_a_nxt = res_a.phase;
          phase_b_nxt = res_b.phase;
          done_a_nxt  = res_a.done;
          done_b_nxt  = res_b.done;
          en_a_nxt    = res_a.en;
          en_b_nxt    = res_b.en;
          cmd.kind    = CMD_TICK;
          cmd.addr_a  = res_a.idx;
          // a tick with both channels off produces nothing: drop it here
          cmd_push    = res_a.en || res_b.en;
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r <= '0;
      phase_b_r <= '0;
      done_a_r  <= '0;
      done_b_r  <= '0;
      en_a_r    <= 1'b0;
      en_b_r    <= 1'b0;
      step_a_r  <= '0;
      step_b_r  <= '0;
      limit_a_r <= '1;
      limit_b_r <= '1;
    end else begin
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
      done_a_r  <= done_a_nxt;
      done_b_r  <= done_b_nxt;
      en_a_r    <= en_a_nxt;
      en_b_r    <= en_b_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEP_A:  step_a_r  <= cfg_data;
          REG_STEP_B:  step_b_r  <= cfg_data;
          REG_LIMIT_A: limit_a_r <= cfg_data[LIMIT_W-1:0];
          REG_LIMIT_B: limit_b_r <= cfg_data[LIMIT_W-1:0];
          default: begin
            step_a_r <= step_a_r;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ddsbp_back.sv
// Back end: applies table writes, reads both tables per tick, emits DAC words.
`timescale 1ns / 1ps
`default_nettype none

module ddsbp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  input  wire ddsbp_pkg::cmd_t cmd,
  output logic                 cmd_pop,
  input  wire logic            out_full,
  output logic                 out_push,
  output ddsbp_pkg::out_t      out_word
);

  import ddsbp_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  logic                pend_a_r, pend_a_nxt;
  logic                pend_b_r, pend_b_nxt;
  logic                head_tick, issue, wr, emit, s1_done, s1_free;
  logic [SAMPLE_W-1:0] smp_a, smp_b;

  ddsbp_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table_a (
    .clk  (clk),
    .we   (wr && !cmd.chan),
    .waddr(cmd.addr_a),
    .wdata(cmd.sample),
    .re   (issue),
    .raddr(cmd.addr_a),
    .rdata(smp_a)
  );

  ddsbp_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table_b (
    .clk  (clk),
    .we   (wr && cmd.chan),
    .waddr(cmd.addr_a),
    .wdata(cmd.sample),
    .re   (issue),
    .raddr(cmd.addr_b),
    .rdata(smp_b)
  );

  assign head_tick = (cmd.kind == CMD_TICK);
  assign emit      = s1_valid_r && !out_full;
  assign s1_done   = emit && (!pend_a_r || !pend_b_r);
  assign s1_free   = !s1_valid_r || s1_done;
  assign issue     = cmd_valid && head_tick && s1_free;
  assign wr        = cmd_valid && !head_tick;
  assign cmd_pop   = issue || wr;
  assign out_push  = emit;

  always_comb begin
    out_word.from_channel = !pend_a_r;
    out_word.last         = !(pend_a_r && pend_b_r);
    if (pend_a_r) begin
      out_word.dac_word = PREFIX_A | DAC_W'(smp_a);
    end else begin
      out_word.dac_word = PREFIX_B | DAC_W'(smp_b);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    pend_a_nxt   = pend_a_r;
    pend_b_nxt   = pend_b_r;
    if (emit) begin
      if (pend_a_r) begin
        pend_a_nxt = 1'b0;
      end else begin
        pend_b_nxt = 1'b0;
      end
    end
    if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
      pend_a_nxt   = cmd.en_a;
      pend_b_nxt   = cmd.en_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_a_r   <= 1'b0;
      pend_b_r   <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      pend_a_r   <= pend_a_nxt;
      pend_b_r   <= pend_b_nxt;
    end
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (pend_a_r || pend_b_r))
    else $error("emit stage busy with nothing pending");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> (!pend_a_r && !pend_b_r))
    else $error("pending word left in idle emit stage");

  a_a_then_b: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pend_a_r && pend_b_r) |=> (s1_valid_r && pend_b_r && !pend_a_r))
    else $error("channel B word lost after channel A word");

endmodule

`default_nettype wire

>>> hw/rtl/dual_channel_dds_burst_player.sv
// Top level of the two-channel DDS burst player.
`timescale 1ns / 1ps
`default_nettype none

// Two-channel DDS burst player. Items pushed on the input queue write a
// 12-bit table entry, arm a channel, start a run or deliver a sample tick;
// each tick yields one DAC word per enabled channel, A before B, with last
// set on the final word of that tick. The front end takes one item per
// cycle while the command queue is not full and keeps phase, period counts
// and enables; a command queue of CMD_DEPTH entries feeds the back end,
// which reads both tables together and then writes one word per cycle,
// while the output queue has room, into an output queue of OUT_DEPTH
// entries. Arm and start stay in the front end; table writes and ticks go
// through the back end. A word passes the command queue, the registered
// table read and the output queue on its way out.
// The tables power up undefined; play only entries that have been written.
module dual_channel_dds_burst_player #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [1:0]                           in_action,
  input  wire logic                                 in_channel,
  input  wire logic [ddsbp_pkg::ADDR_W-1:0]         in_table_index,
  input  wire logic [ddsbp_pkg::SAMPLE_W-1:0]       in_table_sample,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic      [ddsbp_pkg::DAC_W-1:0]          out_dac_word,
  output logic                                      out_from_channel,
  output logic                                      out_last,
  input  wire logic                                 cfg_we,
  input  wire logic [ddsbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ddsbp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import ddsbp_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int OUT_W = $bits(out_t);

  cmd_t             cmd_in, cmd_head;
  logic [CMD_W-1:0] cmd_head_bits;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  out_t             word_in, word_head;
  logic [OUT_W-1:0] word_head_bits;
  logic             word_push, word_full;

  ddsbp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .action      (in_action),
    .channel     (in_channel),
    .table_index (in_table_index),
    .table_sample(in_table_sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  ddsbp_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head_bits),
    .empty(cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_head_bits);

  ddsbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(!cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .out_full (word_full),
    .out_push (word_push),
    .out_word (word_in)
  );

  ddsbp_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (word_push),
    .wdata(word_in),
    .full (word_full),
    .pop  (pop),
    .rdata(word_head_bits),
    .empty(empty)
  );

  assign word_head        = out_t'(word_head_bits);
  assign full             = cmd_full;
  assign out_dac_word     = word_head.dac_word;
  assign out_from_channel = word_head.from_channel;
  assign out_last         = word_head.last;

endmodule

`default_nettype wire

>>> sim/dual_channel_dds_burst_player_tb.sv
// Self-checking testbench for the two-channel DDS burst player.
`timescale 1ns / 1ps

module dual_channel_dds_burst_player_tb;
  import ddsbp_pkg::*;

  localparam int          HALF_ITEMS   = 64;
  localparam int          RAND_PHASES  = 8;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          HOLD_CYCLES  = 120;
  localparam int          GEN          = 0;  // voice state seen by the item generator
  localparam int          CHK          = 1;  // voice state seen by the checker
  localparam logic [26:0] STEP_MAX     = 27'h7FFFFFF;

  typedef struct packed {
    action_t     act;
    logic        chan;
    logic [10:0] idx;
    logic [11:0] smp;
  } item_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            push = 1'b0;
  logic            full;
  logic [1:0]      in_action = 2'd0;
  logic            in_channel = 1'b0;
  logic [10:0]     in_table_index = '0;
  logic [11:0]     in_table_sample = '0;
  logic            empty;
  logic            pop = 1'b0;
  logic [15:0]     out_dac_word;
  logic            out_from_channel;
  logic            out_last;
  logic            cfg_we = 1'b0;
  cfg_reg_t        cfg_index = REG_STEP_A;
  logic [26:0]     cfg_data = '0;

  // player state: registers shared, voices kept once for generation and once for checking
  logic [26:0]     step_cfg [0:1];
  logic [16:0]     limit_cfg [0:1];
  logic [27:0]     ph [0:1][0:1];
  logic [15:0]     laps [0:1][0:1];
  bit              run [0:1][0:1];
  logic [11:0]     wave_tbl [0:1][0:2047];
  bit              written [0:1][0:2047];

  item_t           pending_q[$];
  out_t            dac_words_q[$];

  int              mismatches = 0;
  int              accepted_cnt = 0;
  int              tick_cnt = 0;
  int              silent_ticks = 0;
  int              words_a = 0;
  int              words_b = 0;
  int              got_cnt = 0;
  int              full_stalls = 0;
  int              settings = 1;
  int              burst_left = 0;
  int              gap_left = 0;
  int              hold_left = 0;
  int              cycle_cnt = 0;
  logic [15:0]     pop_pattern = 16'hFFFF;

  dual_channel_dds_burst_player u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_channel       (in_channel),
    .in_table_index   (in_table_index),
    .in_table_sample  (in_table_sample),
    .empty            (empty),
    .pop              (pop),
    .out_dac_word     (out_dac_word),
    .out_from_channel (out_from_channel),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void set_voices(input int m, input action_t a, input logic ch);
    if (a == ACT_START) begin
      for (int c = 0; c < 2; c++) begin
        ph[m][c]   = '0;
        laps[m][c] = '0;
        run[m][c]  = 1'b1;
      end
    end else begin
      run[m][ch] = 1'b1;
    end
  endfunction

  // wrap and limit check on both channels first, then read index and advance
  function automatic void advance_voices(input int m, output logic [1:0] on,
                                         output logic [21:0] rd);
    for (int c = 0; c < 2; c++) begin
      if (ph[m][c][27]) begin
        ph[m][c]   = {1'b0, ph[m][c][26:0]};
        laps[m][c] = laps[m][c] + 16'd1;
      end
      if (!limit_cfg[c][16] && laps[m][c] == limit_cfg[c][15:0])
        run[m][c] = 1'b0;
    end
    for (int c = 0; c < 2; c++) begin
      on[c]           = run[m][c];
      rd[c*11 +: 11]  = ph[m][c][26:16];
      if (run[m][c])
        ph[m][c] = ph[m][c] + {1'b0, step_cfg[c]};
    end
  endfunction

  function automatic void dds_play_item(input item_t it);
    logic [1:0]  on;
    logic [21:0] rd;
    out_t        w;
    case (it.act)
      ACT_WRITE: wave_tbl[it.chan][it.idx] = it.smp;
      ACT_ARM, ACT_START: set_voices(CHK, it.act, it.chan);
      default: begin
        advance_voices(CHK, on, rd);
        tick_cnt++;
        if (on == 2'b00)
          silent_ticks++;
        if (on[0]) begin
          w.dac_word     = PREFIX_A | {4'h0, wave_tbl[0][rd[10:0]]};
          w.from_channel = 1'b0;
          w.last         = ~on[1];
          dac_words_q.push_back(w);
          words_a++;
        end
        if (on[1]) begin
          w.dac_word     = PREFIX_B | {4'h0, wave_tbl[1][rd[21:11]]};
          w.from_channel = 1'b1;
          w.last         = 1'b1;
          dac_words_q.push_back(w);
          words_b++;
        end
      end
    endcase
  endfunction

  function automatic item_t item_of(input action_t a, input logic ch, input logic [10:0] i,
                                    input logic [11:0] s);
    item_t it;
    it.act  = a;
    it.chan = ch;
    it.idx  = i;
    it.smp  = s;
    return it;
  endfunction

  function automatic item_t rand_item();
    logic [31:0] r;
    action_t     a;
    int          pick;
    r    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      a = ACT_TICK;
    else if (pick < 68)
      a = ACT_START;
    else if (pick < 76)
      a = ACT_ARM;
    else
      a = ACT_WRITE;
    return item_of(a, r[0], r[11:1], r[23:12]);
  endfunction

  // queue one transaction; a tick that would play an unwritten entry gets a write first
  function automatic void queue_item(input item_t it);
    logic [1:0]  on;
    logic [21:0] rd;
    logic [31:0] r;
    case (it.act)
      ACT_WRITE: written[it.chan][it.idx] = 1'b1;
      ACT_ARM, ACT_START: set_voices(GEN, it.act, it.chan);
      default: begin
        advance_voices(GEN, on, rd);
        for (int c = 0; c < 2; c++) begin
          if (on[c] && !written[c][rd[c*11 +: 11]]) begin
            r = $urandom;
            pending_q.push_back(item_of(ACT_WRITE, c[0], rd[c*11 +: 11], r[11:0]));
            written[c][rd[c*11 +: 11]] = 1'b1;
          end
        end
      end
    endcase
    pending_q.push_back(it);
  endfunction

  function automatic logic [26:0] pick_step(input int sel);
    logic [31:0] r;
    r = $urandom;
    case (sel)
      0: return '0;
      1: return STEP_MAX;
      2: return 27'h0010000;
      3: return 27'h4000000;
      4: return r[26:0] | 27'h1000000;
      5: return STEP_MAX - {17'h0, r[9:0]};
      default: return r[26:0];
    endcase
  endfunction

  function automatic logic [16:0] pick_limit(input int sel);
    logic [31:0] r;
    r = $urandom;
    case (sel)
      0: return 17'h1FFFF;
      1: return '0;
      2: return 17'h0FFFF;
      3: return {1'b1, r[15:0]};
      4: return 17'd1;
      5: return 17'd2 + {15'h0, r[1:0]};
      default: return {14'h0, r[2:0]};
    endcase
  endfunction

  task automatic reg_write(input cfg_reg_t rg, input logic [26:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rg;
    cfg_data  <= d;
    case (rg)
      REG_STEP_A:  step_cfg[0]  = d;
      REG_STEP_B:  step_cfg[1]  = d;
      REG_LIMIT_A: limit_cfg[0] = d[16:0];
      default:     limit_cfg[1] = d[16:0];
    endcase
  endtask

  // limit writes carry junk above bit 16, which the block must drop
  task automatic set_regs(input logic [26:0] sa, input logic [26:0] sb,
                          input logic [16:0] la, input logic [16:0] lb);
    logic [31:0] r;
    r = $urandom;
    reg_write(REG_STEP_A, sa);
    reg_write(REG_STEP_B, sb);
    reg_write(REG_LIMIT_A, {r[9:0], la});
    reg_write(REG_LIMIT_B, {r[19:10], lb});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || push || dac_words_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // sender: bursts of offers separated by random gaps
  always @(posedge clk) begin
    item_t it;
    logic  offer;
    offer = 1'b0;
    if (rst_n && push && !full) begin
      it = pending_q.pop_front();
      dds_play_item(it);
      accepted_cnt++;
    end else if (push && full) begin
      full_stalls++;
    end
    if (gap_left != 0) begin
      gap_left--;
    end else if (pending_q.size() != 0) begin
      offer = 1'b1;
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        gap_left   = $urandom_range(0, 7);
      end
    end
    push <= offer;
    if (offer) begin
      in_action       <= pending_q[0].act;
      in_channel      <= pending_q[0].chan;
      in_table_index  <= pending_q[0].idx;
      in_table_sample <= pending_q[0].smp;
    end
  end

  // receiver: rotating stall pattern, now and then a long hold-off
  always @(posedge clk) begin
    out_t        w;
    logic [31:0] r;
    if (rst_n && pop && !empty) begin
      got_cnt++;
      if (dac_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected DAC word %h ch %0d last %0d", out_dac_word,
                   out_from_channel, out_last);
      end else begin
        w = dac_words_q.pop_front();
        if (out_dac_word !== w.dac_word || out_from_channel !== w.from_channel ||
            out_last !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("DAC word %0d: expected %h ch %0d last %0d, got %h ch %0d last %0d",
                     got_cnt, w.dac_word, w.from_channel, w.last, out_dac_word,
                     out_from_channel, out_last);
        end
      end
      if (got_cnt % 500 == 150)
        hold_left = HOLD_CYCLES;
    end
    cycle_cnt++;
    if (cycle_cnt % 64 == 0) begin
      r = $urandom;
      case ($urandom_range(0, 3))
        0: pop_pattern = 16'hFFFF;
        1: pop_pattern = r[15:0] | 16'h0001;
        2: pop_pattern = r[15:0] | r[31:16];
        default: pop_pattern = (r[15:0] & r[31:16]) | 16'h0001;
      endcase
    end
    pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= pop_pattern[0];
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      step_cfg[c]  = '0;
      limit_cfg[c] = 17'h1FFFF;
      for (int m = 0; m < 2; m++) begin
        ph[m][c]   = '0;
        laps[m][c] = '0;
        run[m][c]  = 1'b0;
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: idle tick, table extremes, arm one channel then both, start
    queue_item(item_of(ACT_TICK, 1'b1, 11'h7FF, 12'hFFF));
    queue_item(item_of(ACT_WRITE, 1'b0, 11'd0, 12'h000));
    queue_item(item_of(ACT_WRITE, 1'b0, 11'd2047, 12'hFFF));
    queue_item(item_of(ACT_WRITE, 1'b1, 11'd0, 12'hFFF));
    queue_item(item_of(ACT_WRITE, 1'b1, 11'd2047, 12'h000));
    queue_item(item_of(ACT_WRITE, 1'b0, 11'd1, 12'hA5A));
    queue_item(item_of(ACT_WRITE, 1'b1, 11'd1, 12'h5A5));
    queue_item(item_of(ACT_ARM, 1'b0, 11'h555, 12'hAAA));
    queue_item(item_of(ACT_TICK, 1'b0, 11'h2AA, 12'h555));
    queue_item(item_of(ACT_ARM, 1'b1, 11'h0, 12'h0));
    queue_item(item_of(ACT_TICK, 1'b0, 11'h0, 12'h0));
    queue_item(item_of(ACT_START, 1'b1, 11'h7FF, 12'hFFF));
    queue_item(item_of(ACT_TICK, 1'b1, 11'h0, 12'h0));
    queue_item(item_of(ACT_TICK, 1'b0, 11'h0, 12'h0));
    wait_idle();

    // zero limit stops A at once, B stops after two wraps; arm cannot revive A
    set_regs(STEP_MAX, 27'h4000000, 17'd0, 17'd2);
    queue_item(item_of(ACT_START, 1'b0, 11'h0, 12'h0));
    repeat (6) queue_item(item_of(ACT_TICK, 1'b0, 11'h0, 12'h0));
    queue_item(item_of(ACT_ARM, 1'b0, 11'h0, 12'h0));
    repeat (2) queue_item(item_of(ACT_TICK, 1'b1, 11'h0, 12'h0));
    wait_idle();

    for (int k = 0; k < RAND_PHASES; k++) begin
      set_regs(pick_step(k), pick_step((k + 5) % 8), pick_limit(k), pick_limit((k + 3) % 8));
      // hold back the second half until the first has fully drained
      repeat (2) begin
        repeat (HALF_ITEMS) queue_item(rand_item());
        wait_idle();
      end
    end

    $display("Covered %0d input transactions, %0d ticks (%0d silent), %0d register settings",
             accepted_cnt, tick_cnt, silent_ticks, settings);
    $display("Checked %0d DAC words (%0d A, %0d B); input held off by full for %0d cycles",
             got_cnt, words_a, words_b, full_stalls);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ddsbp_pkg.sv
hw/rtl/ddsbp_ram.sv
hw/rtl/ddsbp_fifo.sv
hw/rtl/ddsbp_front.sv
hw/rtl/ddsbp_back.sv
hw/rtl/dual_channel_dds_burst_player.sv
sim/dual_channel_dds_burst_player_tb.sv
